// ----- design/window_pool_eight_lane_macros.svh -----
// Assertion macros for the window pooling block.
`ifndef WINDOW_POOL_EIGHT_LANE_MACROS_SVH
`define WINDOW_POOL_EIGHT_LANE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define WPEL_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define WPEL_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- design/wpel_pkg.sv -----
// Shared types and constants of the window pooling block.
package wpel_pkg;

   localparam int SAMPLE_BITS     = 16;
   localparam int OUT_BITS        = 16;
   localparam int ACC_BITS        = 28;
   localparam int COUNT_BITS      = 13;
   localparam int MAX_LANES       = 8;
   localparam int LANES_DEF       = 8;
   localparam int WINDOW_MAX_DEF  = 4096;
   localparam int DIV_CNT_BITS    = $clog2(ACC_BITS);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [OUT_BITS-1:0]    pooled_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;

   localparam acc_type ACC_START_MAX =
      {{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
   localparam acc_type ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam acc_type ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   typedef struct packed {
      logic fold;
      logic load;
      logic restart;
      logic mean;
      logic abs_en;
      logic div_en;
   } lane_ctrl_type;

   typedef struct packed {
      logic                sign;
      logic [ACC_BITS-1:0] mag;
   } lane_res_type;

endpackage

// ----- design/wpel_lane.sv -----
// One pooling lane: running max or saturating sum, then a restoring divider.
module wpel_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  wpel_pkg::lane_ctrl_type        ctrl,
   input  wpel_pkg::sample_type           sample,
   input  logic [wpel_pkg::COUNT_BITS-1:0] divisor,
   output wpel_pkg::lane_res_type         result
);
   import wpel_pkg::*;

   acc_type                 acc_ff, acc_in;
   acc_type                 folded;
   acc_type                 start_val;
   acc_type                 sample_ext;
   logic signed [ACC_BITS:0] sum_wide;
   logic [ACC_BITS-1:0]     num_ff, num_in;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic                    sign_ff, sign_in;
   logic [COUNT_BITS:0]     trial;
   logic [COUNT_BITS:0]     trial_diff;

   assign sample_ext = {{(ACC_BITS-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
   assign sum_wide   = {acc_ff[ACC_BITS-1], acc_ff} + {sample_ext[ACC_BITS-1], sample_ext};
   assign start_val  = ctrl.mean ? '0 : ACC_START_MAX;

   always_comb begin
      if (ctrl.mean) begin
         if (sum_wide[ACC_BITS] != sum_wide[ACC_BITS-1]) begin
            folded = sum_wide[ACC_BITS] ? ACC_MIN : ACC_MAX;
         end else begin
            folded = sum_wide[ACC_BITS-1:0];
         end
      end else begin
         folded = (sample_ext > acc_ff) ? sample_ext : acc_ff;
      end
   end

   always_comb begin
      priority if (ctrl.restart || ctrl.load) begin
         acc_in = start_val;
      end else if (ctrl.fold) begin
         acc_in = folded;
      end else begin
         acc_in = acc_ff;
      end
   end

   assign trial      = {rem_ff, num_ff[ACC_BITS-1]};
   assign trial_diff = trial - {1'b0, divisor};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      sign_in = sign_ff;
      priority if (ctrl.load) begin
         num_in = folded;
      end else if (ctrl.abs_en) begin
         sign_in = num_ff[ACC_BITS-1];
         num_in  = num_ff[ACC_BITS-1] ? (~num_ff + 1'b1) : num_ff;
         rem_in  = '0;
      end else if (ctrl.div_en) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial_diff[COUNT_BITS-1:0];
            num_in = {num_ff[ACC_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[COUNT_BITS-1:0];
            num_in = {num_ff[ACC_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= ACC_START_MAX;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      sign_ff <= sign_in;
   end

   assign result.sign = sign_ff;
   assign result.mag  = num_ff;

endmodule

// ----- design/wpel_merge.sv -----
// Merge stage: saturates every lane result and holds the response register.
module wpel_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  wpel_pkg::lane_res_type lane_res [wpel_pkg::MAX_LANES],
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output wpel_pkg::pooled_type   rsp_pooled [wpel_pkg::MAX_LANES],
   output logic                   out_free
);
   import wpel_pkg::*;

   localparam logic [ACC_BITS-1:0] POS_LIMIT = ACC_BITS'((2**(OUT_BITS-1)) - 1);
   localparam logic [ACC_BITS-1:0] NEG_LIMIT = ACC_BITS'(2**(OUT_BITS-1));

   logic       rsp_valid_ff, rsp_valid_in;
   pooled_type pooled_ff [MAX_LANES];
   pooled_type pooled_in [MAX_LANES];

   always_comb begin
      for (int i = 0; i < MAX_LANES; i++) begin
         if (!lane_res[i].sign) begin
            pooled_in[i] = (lane_res[i].mag > POS_LIMIT) ? {1'b0, {(OUT_BITS-1){1'b1}}}
                                                        : lane_res[i].mag[OUT_BITS-1:0];
         end else begin
            pooled_in[i] = (lane_res[i].mag > NEG_LIMIT) ? {1'b1, {(OUT_BITS-1){1'b0}}}
                                                        : -lane_res[i].mag[OUT_BITS-1:0];
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      priority if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pooled_ff <= pooled_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pooled = pooled_ff;

endmodule

// ----- design/window_pool_eight_lane.sv -----
// Window pooling top level: eight pooling lanes, shared control, merge stage.
// Non-last requests are taken one per cycle and fold in the cycle they arrive.
// After a last request each lane takes the absolute value; in mean mode it then
// divides by the pool count (one quotient bit per cycle in each lane) before the response is loaded.
// The block stalls requests until the response enters the output register.
// Synchronous reset selects max mode and restarts every accumulator.
module window_pool_eight_lane #(
   parameter int LANES      = wpel_pkg::LANES_DEF,
   parameter int WINDOW_MAX = wpel_pkg::WINDOW_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  wpel_pkg::sample_type            req_lane0_sample,
   input  wpel_pkg::sample_type            req_lane1_sample,
   input  wpel_pkg::sample_type            req_lane2_sample,
   input  wpel_pkg::sample_type            req_lane3_sample,
   input  wpel_pkg::sample_type            req_lane4_sample,
   input  wpel_pkg::sample_type            req_lane5_sample,
   input  wpel_pkg::sample_type            req_lane6_sample,
   input  wpel_pkg::sample_type            req_lane7_sample,
   input  logic                            req_window_last,
   input  logic [wpel_pkg::COUNT_BITS-1:0] req_pool_count,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output wpel_pkg::pooled_type            rsp_lane0_pooled,
   output wpel_pkg::pooled_type            rsp_lane1_pooled,
   output wpel_pkg::pooled_type            rsp_lane2_pooled,
   output wpel_pkg::pooled_type            rsp_lane3_pooled,
   output wpel_pkg::pooled_type            rsp_lane4_pooled,
   output wpel_pkg::pooled_type            rsp_lane5_pooled,
   output wpel_pkg::pooled_type            rsp_lane6_pooled,
   output wpel_pkg::pooled_type            rsp_lane7_pooled,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_pooling_mode
);
   import wpel_pkg::*;

   localparam int COUNT_MAX = (2**COUNT_BITS) - 1;
   localparam int DIV_CAP   = (WINDOW_MAX > COUNT_MAX) ? COUNT_MAX : WINDOW_MAX;

   localparam logic [1:0] ST_RUN = 2'd0;
   localparam logic [1:0] ST_ABS = 2'd1;
   localparam logic [1:0] ST_DIV = 2'd2;
   localparam logic [1:0] ST_OUT = 2'd3;

   localparam logic [DIV_CNT_BITS-1:0] CNT_LAST = DIV_CNT_BITS'(ACC_BITS - 1);

   logic [1:0]              state_ff, state_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    mode_ff, mode_in;
   logic [COUNT_BITS-1:0]   divisor_ff, divisor_in;
   logic                    req_acc;
   logic                    csr_wr;
   logic                    out_load;
   logic                    out_free;
   lane_ctrl_type           lane_ctrl;
   sample_type              samples [MAX_LANES];
   lane_res_type            lane_res [MAX_LANES];
   pooled_type              pooled [MAX_LANES];

   assign req_stall = (state_ff != ST_RUN);
   assign csr_ready = (state_ff == ST_RUN);
   assign req_acc   = req_valid && !req_stall;
   assign csr_wr    = csr_valid && csr_ready;
   assign out_load  = (state_ff == ST_OUT) && out_free;

   assign samples[0] = req_lane0_sample;
   assign samples[1] = req_lane1_sample;
   assign samples[2] = req_lane2_sample;
   assign samples[3] = req_lane3_sample;
   assign samples[4] = req_lane4_sample;
   assign samples[5] = req_lane5_sample;
   assign samples[6] = req_lane6_sample;
   assign samples[7] = req_lane7_sample;

   assign lane_ctrl.fold    = req_acc;
   assign lane_ctrl.load    = req_acc && req_window_last;
   assign lane_ctrl.restart = csr_wr;
   assign lane_ctrl.mean    = csr_wr ? csr_pooling_mode : mode_ff;
   assign lane_ctrl.abs_en  = (state_ff == ST_ABS);
   assign lane_ctrl.div_en  = (state_ff == ST_DIV);

   assign mode_in = csr_wr ? csr_pooling_mode : mode_ff;

   always_comb begin
      divisor_in = divisor_ff;
      if (lane_ctrl.load) begin
         priority if (req_pool_count == '0) begin
            divisor_in = COUNT_BITS'(1);
         end else if (int'(req_pool_count) > DIV_CAP) begin
            divisor_in = COUNT_BITS'(DIV_CAP);
         end else begin
            divisor_in = req_pool_count;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (lane_ctrl.load) begin
               state_in = ST_ABS;
            end
         end
         ST_ABS: begin
            cnt_in   = '0;
            state_in = mode_ff ? ST_DIV : ST_OUT;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_RUN;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         cnt_ff   <= '0;
         mode_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         mode_ff  <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
   end

   for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
      if (g < LANES) begin : g_on
         wpel_lane u_lane (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (lane_ctrl),
            .sample  (samples[g]),
            .divisor (divisor_ff),
            .result  (lane_res[g])
         );
      end else begin : g_off
         assign lane_res[g] = '0;
      end
   end

   wpel_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .lane_res   (lane_res),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_pooled (pooled),
      .out_free   (out_free)
   );

   assign rsp_lane0_pooled = pooled[0];
   assign rsp_lane1_pooled = pooled[1];
   assign rsp_lane2_pooled = pooled[2];
   assign rsp_lane3_pooled = pooled[3];
   assign rsp_lane4_pooled = pooled[4];
   assign rsp_lane5_pooled = pooled[5];
   assign rsp_lane6_pooled = pooled[6];
   assign rsp_lane7_pooled = pooled[7];

`include "window_pool_eight_lane_macros.svh"

   `WPEL_ASSERT_NEXT(a_last_starts_abs, clock, reset, req_acc && req_window_last, state_ff == ST_ABS, "last request did not start the result sequence")
   `WPEL_ASSERT_NEXT(a_div_ends, clock, reset, (state_ff == ST_DIV) && (cnt_ff == CNT_LAST), state_ff == ST_OUT, "divider overran its bit count")
   `WPEL_ASSERT_NOW(a_rsp_from_out, clock, reset, $rose(rsp_valid), $past(state_ff) == ST_OUT, "response appeared outside the output step")
   `WPEL_ASSERT_NEXT(a_max_skips_div, clock, reset, (state_ff == ST_ABS) && !mode_ff, state_ff == ST_OUT, "max mode entered the divider")

endmodule
